// ----- hw/rtl/oams_pkg.sv -----
// shared types, constants and codes of the obstacle avoidance motor sequencer
package oams_pkg;

    localparam int COUNT_W    = 16;
    localparam int DIST_W     = 15;
    localparam int DUR_W      = 16;
    localparam int LIMIT_W    = 15;
    localparam int ACT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SLOTS      = 9;
    localparam int SLOT_W     = 4;

    // distance = floor(count * 34 / 100) = (count * DIST_MUL) >> DIST_SHIFT, exact for 16 bits
    localparam int                DIST_MUL_W = 20;
    localparam int                PROD_W     = COUNT_W + DIST_MUL_W;
    localparam int                DIST_SHIFT = 21;
    localparam logic [DIST_MUL_W-1:0] DIST_MUL = 20'd713032;

    localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RST       = 15'd300;
    localparam logic [LIMIT_W-1:0] FAR_LIMIT_RST        = 15'd500;
    localparam logic [DUR_W-1:0]   PAUSE_MS_RST         = 16'd50;
    localparam logic [DUR_W-1:0]   FRONT_BACKOFF_MS_RST = 16'd600;
    localparam logic [DUR_W-1:0]   NEAR_BACKOFF_MS_RST  = 16'd400;
    localparam logic [DUR_W-1:0]   TURN_MS_RST          = 16'd400;
    localparam logic [DUR_W-1:0]   NUDGE_MS_RST         = 16'd200;

    typedef enum logic [ACT_W-1:0] {
        ACT_STOP  = 3'd0,
        ACT_FWD   = 3'd1,
        ACT_BACK  = 3'd2,
        ACT_LEFT  = 3'd3,
        ACT_RIGHT = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_LIMIT       = 3'd0,
        CFG_FAR_LIMIT        = 3'd1,
        CFG_PAUSE_MS         = 3'd2,
        CFG_FRONT_BACKOFF_MS = 3'd3,
        CFG_NEAR_BACKOFF_MS  = 3'd4,
        CFG_TURN_MS          = 3'd5,
        CFG_NUDGE_MS         = 3'd6
    } t_cfg_idx;

    // positions of one run: front block, nudge, distance band block
    typedef enum logic [SLOT_W-1:0] {
        SL_F_STOP0 = 4'd0,
        SL_F_BACK  = 4'd1,
        SL_F_STOP1 = 4'd2,
        SL_F_TURN  = 4'd3,
        SL_NUDGE   = 4'd4,
        SL_N_STOP  = 4'd5,
        SL_N_BACK  = 4'd6,
        SL_B_STOP  = 4'd7,
        SL_B_END   = 4'd8
    } t_slot;

    typedef struct packed {
        logic [LIMIT_W-1:0] near_limit;
        logic [LIMIT_W-1:0] far_limit;
        logic [DUR_W-1:0]   pause_ms;
        logic [DUR_W-1:0]   front_backoff_ms;
        logic [DUR_W-1:0]   near_backoff_ms;
        logic [DUR_W-1:0]   turn_ms;
        logic [DUR_W-1:0]   nudge_ms;
    } t_cfg;

    typedef struct packed {
        logic              front;
        logic              nudge_left;
        logic              nudge_right;
        logic              coin;
        logic [DIST_W-1:0] distance;
    } t_meas;

endpackage

// ----- hw/rtl/oams_in_if.sv -----
// sensing event channel
interface oams_in_if;
    logic                       valid;
    logic                       ready;
    logic [oams_pkg::COUNT_W-1:0] echo_count;
    logic                       front_clear;
    logic                       left_line;
    logic                       right_line;
    logic                       coin;

    modport source (output valid, echo_count, front_clear, left_line, right_line, coin,
                    input ready);
    modport sink   (input valid, echo_count, front_clear, left_line, right_line, coin,
                    output ready);
endinterface

// ----- hw/rtl/oams_out_if.sv -----
// motor action channel
interface oams_out_if;
    logic                        valid;
    logic                        ready;
    logic [oams_pkg::ACT_W-1:0]  action;
    logic [oams_pkg::DUR_W-1:0]  duration_ms;
    logic [oams_pkg::DIST_W-1:0] distance;
    logic                        last;

    modport source (output valid, action, duration_ms, distance, last, input ready);
    modport sink   (input valid, action, duration_ms, distance, last, output ready);
endinterface

// ----- hw/rtl/obstacle_avoid_motor_sequencer.sv -----
// top level of the obstacle avoidance motor sequencer
//
//  channel  dir  handshake     payload
//  i_in     in   valid/ready   echo_count, front_clear, left_line, right_line, coin
//  o_out    out  valid/ready   action, duration_ms, distance, last
//  i_cfg_*  in   write enable  register index, write data
//
// one action leaves per cycle while the output takes it; an item gives 1 to 9 actions
// the first action of an item passes the input, multiply, plan and output registers
// a new sensing event is taken every cycle while the two front stages have room
// an output stall holds the emitter; the front stages keep filling behind it
// synchronous reset clears handshake state and forgets the turn direction
module obstacle_avoid_motor_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    oams_in_if.sink                         i_in,
    oams_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [oams_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [oams_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    oams_pkg::t_cfg  w_cfg;
    oams_pkg::t_meas w_meas;
    logic            w_meas_valid;
    logic            w_meas_ready;

    oams_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    oams_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_meas_valid),
        .i_ready (w_meas_ready),
        .o_meas  (w_meas)
    );

    oams_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_meas_valid),
        .o_ready (w_meas_ready),
        .i_meas  (w_meas),
        .i_cfg   (w_cfg),
        .o_out   (o_out)
    );

endmodule

// ----- hw/rtl/oams_cfg.sv -----
// configuration register file
module oams_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [oams_pkg::CFG_IDX_W-1:0]    i_idx,
    input  logic [oams_pkg::CFG_DATA_W-1:0]   i_data,
    output oams_pkg::t_cfg                    o_cfg
);

    oams_pkg::t_cfg r_cfg;
    oams_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_idx)
                oams_pkg::CFG_NEAR_LIMIT:       n_cfg.near_limit = i_data[oams_pkg::LIMIT_W-1:0];
                oams_pkg::CFG_FAR_LIMIT:        n_cfg.far_limit = i_data[oams_pkg::LIMIT_W-1:0];
                oams_pkg::CFG_PAUSE_MS:         n_cfg.pause_ms = i_data;
                oams_pkg::CFG_FRONT_BACKOFF_MS: n_cfg.front_backoff_ms = i_data;
                oams_pkg::CFG_NEAR_BACKOFF_MS:  n_cfg.near_backoff_ms = i_data;
                oams_pkg::CFG_TURN_MS:          n_cfg.turn_ms = i_data;
                oams_pkg::CFG_NUDGE_MS:         n_cfg.nudge_ms = i_data;
                default:                        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_limit       <= oams_pkg::NEAR_LIMIT_RST;
            r_cfg.far_limit        <= oams_pkg::FAR_LIMIT_RST;
            r_cfg.pause_ms         <= oams_pkg::PAUSE_MS_RST;
            r_cfg.front_backoff_ms <= oams_pkg::FRONT_BACKOFF_MS_RST;
            r_cfg.near_backoff_ms  <= oams_pkg::NEAR_BACKOFF_MS_RST;
            r_cfg.turn_ms          <= oams_pkg::TURN_MS_RST;
            r_cfg.nudge_ms         <= oams_pkg::NUDGE_MS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/oams_dist.sv -----
// input register and distance multiply stage
module oams_dist (
    input  logic           i_clk,
    input  logic           i_rst_n,
    oams_in_if.sink        i_in,
    output logic           o_valid,
    input  logic           i_ready,
    output oams_pkg::t_meas o_meas
);

    logic                           r_s1_valid;
    logic [oams_pkg::COUNT_W-1:0]   r_count;
    logic                           r_front;
    logic                           r_left;
    logic                           r_right;
    logic                           r_coin;
    logic                           r_s2_valid;
    oams_pkg::t_meas                r_meas;

    logic                           w_s2_free;
    logic                           w_s1_move;
    logic                           w_s1_free;
    logic [oams_pkg::PROD_W-1:0]    w_prod;
    oams_pkg::t_meas                w_meas;

    assign w_s2_free = !r_s2_valid || i_ready;
    assign w_s1_move = r_s1_valid && w_s2_free;
    assign w_s1_free = !r_s1_valid || w_s2_free;
    assign i_in.ready = w_s1_free;

    assign w_prod = {{oams_pkg::DIST_MUL_W{1'b0}}, r_count}
                  * {{oams_pkg::COUNT_W{1'b0}}, oams_pkg::DIST_MUL};

    always_comb begin
        w_meas.front       = !r_front;
        w_meas.nudge_left  = !r_left && r_right;
        w_meas.nudge_right = r_left && !r_right;
        w_meas.coin        = r_coin;
        w_meas.distance    = w_prod[oams_pkg::DIST_SHIFT +: oams_pkg::DIST_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_s1_free) begin
            r_count <= i_in.echo_count;
            r_front <= i_in.front_clear;
            r_left  <= i_in.left_line;
            r_right <= i_in.right_line;
            r_coin  <= i_in.coin;
        end
        if (w_s1_move) begin
            r_meas <= w_meas;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_meas  = r_meas;

endmodule

// ----- hw/rtl/oams_seq.sv -----
// run planner, action emitter and output register
module oams_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  oams_pkg::t_meas i_meas,
    input  oams_pkg::t_cfg  i_cfg,
    oams_out_if.source      o_out
);

    function automatic logic [oams_pkg::SLOT_W-1:0] first_slot(
        input logic [oams_pkg::SLOTS-1:0]  en,
        input logic [oams_pkg::SLOT_W-1:0] from
    );
        logic [oams_pkg::SLOT_W-1:0] res;
        logic                        found;
        res   = oams_pkg::SL_B_END;
        found = 1'b0;
        for (int i = 0; i < oams_pkg::SLOTS; i++) begin
            if (!found && en[i] && (oams_pkg::SLOT_W'(i) >= from)) begin
                res   = oams_pkg::SLOT_W'(i);
                found = 1'b1;
            end
        end
        return res;
    endfunction

    logic                            r_busy;
    logic [oams_pkg::SLOT_W-1:0]     r_slot;
    logic [oams_pkg::SLOTS-1:0]      r_en;
    oams_pkg::t_action               r_turn;
    oams_pkg::t_action               r_nudge;
    logic                            r_far;
    logic [oams_pkg::DIST_W-1:0]     r_distance;
    oams_pkg::t_dir                  r_dir;
    logic                            r_out_valid;
    oams_pkg::t_action               r_out_action;
    logic [oams_pkg::DUR_W-1:0]      r_out_duration;
    logic [oams_pkg::DIST_W-1:0]     r_out_distance;
    logic                            r_out_last;

    logic                            w_emit;
    logic                            w_done;
    logic                            w_load;
    logic                            w_near;
    logic                            w_mid;
    logic                            w_far;
    oams_pkg::t_action               w_turn;
    logic [oams_pkg::SLOTS-1:0]      w_en;
    oams_pkg::t_action               w_act;
    logic [oams_pkg::DUR_W-1:0]      w_dur;
    logic [oams_pkg::SLOT_W-1:0]     w_next_slot;

    assign w_emit  = r_busy && (!r_out_valid || o_out.ready);
    assign w_done  = w_emit && (r_slot == oams_pkg::SL_B_END);
    assign o_ready = !r_busy || w_done;
    assign w_load  = i_valid && o_ready;

    // plan of the incoming item
    always_comb begin
        w_near = i_meas.distance < i_cfg.near_limit;
        w_mid  = !w_near && (i_meas.distance < i_cfg.far_limit);
        w_far  = !w_near && !w_mid;
        case (r_dir)
            oams_pkg::DIR_LEFT:  w_turn = oams_pkg::ACT_LEFT;
            oams_pkg::DIR_RIGHT: w_turn = oams_pkg::ACT_RIGHT;
            default:             w_turn = i_meas.coin ? oams_pkg::ACT_LEFT : oams_pkg::ACT_RIGHT;
        endcase
        w_en                      = '0;
        w_en[oams_pkg::SL_F_STOP0] = i_meas.front;
        w_en[oams_pkg::SL_F_BACK]  = i_meas.front;
        w_en[oams_pkg::SL_F_STOP1] = i_meas.front;
        w_en[oams_pkg::SL_F_TURN]  = i_meas.front;
        w_en[oams_pkg::SL_NUDGE]   = i_meas.nudge_left || i_meas.nudge_right;
        w_en[oams_pkg::SL_N_STOP]  = w_near;
        w_en[oams_pkg::SL_N_BACK]  = w_near;
        w_en[oams_pkg::SL_B_STOP]  = w_near || w_mid;
        w_en[oams_pkg::SL_B_END]   = 1'b1;
    end

    // action of the current position
    always_comb begin
        case (r_slot)
            oams_pkg::SL_F_STOP0, oams_pkg::SL_F_STOP1,
            oams_pkg::SL_N_STOP, oams_pkg::SL_B_STOP: begin
                w_act = oams_pkg::ACT_STOP;
                w_dur = i_cfg.pause_ms;
            end
            oams_pkg::SL_F_BACK: begin
                w_act = oams_pkg::ACT_BACK;
                w_dur = i_cfg.front_backoff_ms;
            end
            oams_pkg::SL_N_BACK: begin
                w_act = oams_pkg::ACT_BACK;
                w_dur = i_cfg.near_backoff_ms;
            end
            oams_pkg::SL_F_TURN: begin
                w_act = r_turn;
                w_dur = i_cfg.turn_ms;
            end
            oams_pkg::SL_NUDGE: begin
                w_act = r_nudge;
                w_dur = i_cfg.nudge_ms;
            end
            oams_pkg::SL_B_END: begin
                w_act = r_far ? oams_pkg::ACT_FWD : r_turn;
                w_dur = r_far ? '0 : i_cfg.turn_ms;
            end
            default: begin
                w_act = oams_pkg::ACT_STOP;
                w_dur = '0;
            end
        endcase
        w_next_slot = first_slot(r_en, r_slot + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_slot      <= oams_pkg::SL_B_END;
            r_dir       <= oams_pkg::DIR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_slot <= first_slot(w_en, oams_pkg::SL_F_STOP0);
                r_dir  <= w_far ? oams_pkg::DIR_NONE
                        : ((w_turn == oams_pkg::ACT_LEFT) ? oams_pkg::DIR_LEFT
                                                          : oams_pkg::DIR_RIGHT);
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (w_emit) begin
                r_slot <= w_next_slot;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_en       <= w_en;
            r_turn     <= w_turn;
            r_nudge    <= i_meas.nudge_left ? oams_pkg::ACT_LEFT : oams_pkg::ACT_RIGHT;
            r_far      <= w_far;
            r_distance <= i_meas.distance;
        end
        if (w_emit) begin
            r_out_action   <= w_act;
            r_out_duration <= w_dur;
            r_out_distance <= r_distance;
            r_out_last     <= (r_slot == oams_pkg::SL_B_END);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.action      = r_out_action;
    assign o_out.duration_ms = r_out_duration;
    assign o_out.distance    = r_out_distance;
    assign o_out.last        = r_out_last;

endmodule

// ----- hw/rtl/oams_checker.sv -----
// port level assertions for the sequencer, bound to the top level
module oams_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [oams_pkg::ACT_W-1:0]  i_out_action,
    input logic                        i_out_last
);

    // a stalled transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_fwd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_action == oams_pkg::ACT_FWD) |-> i_out_last)
        else $error("forward action not at end of run");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |->
            (i_out_action == oams_pkg::ACT_FWD) || (i_out_action == oams_pkg::ACT_LEFT)
            || (i_out_action == oams_pkg::ACT_RIGHT))
        else $error("run ends on stop or backward");

endmodule

bind obstacle_avoid_motor_sequencer oams_checker u_oams_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_action (o_out.action),
    .i_out_last   (o_out.last)
);

// ----- tb/obstacle_avoid_motor_sequencer_tb.sv -----
// testbench of the obstacle avoidance motor sequencer: predicted action runs checked per transaction
module obstacle_avoid_motor_sequencer_tb;

    localparam int                             CLK_HALF       = 6;
    localparam int                             RST_CYCLES     = 10;
    localparam int                             SETTLE_CYCLES  = 12;
    localparam int                             STALL_CYCLES   = 300;
    localparam int                             PHASE_ITEMS    = 38;
    localparam int                             IDLE_PCT       = 12;
    localparam int                             TIMEOUT_CYCLES = 150000;
    localparam logic [oams_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam logic [oams_pkg::LIMIT_W-1:0]   LIMIT_TOP      = 15'd22282;

    typedef struct {
        oams_pkg::t_action           act;
        logic [oams_pkg::DUR_W-1:0]  dur;
        logic [oams_pkg::DIST_W-1:0] distance;
        logic                        last;
    } t_motor_step;

    class motor_run_predictor;
        oams_pkg::t_cfg              regs;
        oams_pkg::t_dir              heading;
        logic [oams_pkg::DIST_W-1:0] cur_dist;
        t_motor_step                 due_actions[$];
        int                          errors;

        function new();
            regs.near_limit       = oams_pkg::NEAR_LIMIT_RST;
            regs.far_limit        = oams_pkg::FAR_LIMIT_RST;
            regs.pause_ms         = oams_pkg::PAUSE_MS_RST;
            regs.front_backoff_ms = oams_pkg::FRONT_BACKOFF_MS_RST;
            regs.near_backoff_ms  = oams_pkg::NEAR_BACKOFF_MS_RST;
            regs.turn_ms          = oams_pkg::TURN_MS_RST;
            regs.nudge_ms         = oams_pkg::NUDGE_MS_RST;
            heading               = oams_pkg::DIR_NONE;
            cur_dist              = '0;
            errors                = 0;
        endfunction

        function void set_reg(logic [oams_pkg::CFG_IDX_W-1:0] idx,
                              logic [oams_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                oams_pkg::CFG_NEAR_LIMIT:       regs.near_limit       = data[oams_pkg::LIMIT_W-1:0];
                oams_pkg::CFG_FAR_LIMIT:        regs.far_limit        = data[oams_pkg::LIMIT_W-1:0];
                oams_pkg::CFG_PAUSE_MS:         regs.pause_ms         = data;
                oams_pkg::CFG_FRONT_BACKOFF_MS: regs.front_backoff_ms = data;
                oams_pkg::CFG_NEAR_BACKOFF_MS:  regs.near_backoff_ms  = data;
                oams_pkg::CFG_TURN_MS:          regs.turn_ms          = data;
                oams_pkg::CFG_NUDGE_MS:         regs.nudge_ms         = data;
                default: ;
            endcase
        endfunction

        function void push_step(oams_pkg::t_action a, logic [oams_pkg::DUR_W-1:0] d);
            t_motor_step s;
            s.act      = a;
            s.dur      = d;
            s.distance = cur_dist;
            s.last     = 1'b0;
            due_actions.push_back(s);
        endfunction

        function void turn(logic coin);
            if (heading == oams_pkg::DIR_LEFT) begin
                push_step(oams_pkg::ACT_LEFT, regs.turn_ms);
            end else if (heading == oams_pkg::DIR_RIGHT) begin
                push_step(oams_pkg::ACT_RIGHT, regs.turn_ms);
            end else if (coin) begin
                heading = oams_pkg::DIR_LEFT;
                push_step(oams_pkg::ACT_LEFT, regs.turn_ms);
            end else begin
                heading = oams_pkg::DIR_RIGHT;
                push_step(oams_pkg::ACT_RIGHT, regs.turn_ms);
            end
        endfunction

        function void note_event(logic [oams_pkg::COUNT_W-1:0] cnt, logic front_clear,
                                 logic left_line, logic right_line, logic coin);
            int unsigned ticks;
            t_motor_step tail;
            ticks    = 32'(cnt);
            cur_dist = oams_pkg::DIST_W'((ticks * 34) / 100);
            if (!front_clear) begin
                push_step(oams_pkg::ACT_STOP, regs.pause_ms);
                push_step(oams_pkg::ACT_BACK, regs.front_backoff_ms);
                push_step(oams_pkg::ACT_STOP, regs.pause_ms);
                turn(coin);
            end
            if (left_line && !right_line) push_step(oams_pkg::ACT_RIGHT, regs.nudge_ms);
            if (!left_line && right_line) push_step(oams_pkg::ACT_LEFT, regs.nudge_ms);
            if (cur_dist < regs.near_limit) begin
                push_step(oams_pkg::ACT_STOP, regs.pause_ms);
                push_step(oams_pkg::ACT_BACK, regs.near_backoff_ms);
                push_step(oams_pkg::ACT_STOP, regs.pause_ms);
                turn(coin);
            end else if (cur_dist < regs.far_limit) begin
                push_step(oams_pkg::ACT_STOP, regs.pause_ms);
                turn(coin);
            end else begin
                push_step(oams_pkg::ACT_FWD, '0);
                heading = oams_pkg::DIR_NONE;
            end
            tail      = due_actions.pop_back();
            tail.last = 1'b1;
            due_actions.push_back(tail);
        endfunction

        function void check_action(logic [oams_pkg::ACT_W-1:0] act,
                                   logic [oams_pkg::DUR_W-1:0] dur,
                                   logic [oams_pkg::DIST_W-1:0] distance, logic last);
            t_motor_step want;
            if (due_actions.size() == 0) begin
                $error("unexpected transaction: action %0d duration_ms %0d", act, dur);
                errors++;
                return;
            end
            want = due_actions.pop_front();
            if (act !== want.act) begin
                $error("action: expected %0d, actual %0d", want.act, act);
                errors++;
            end
            if (dur !== want.dur) begin
                $error("duration_ms: expected %0d, actual %0d", want.dur, dur);
                errors++;
            end
            if (distance !== want.distance) begin
                $error("distance: expected %0d, actual %0d", want.distance, distance);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [oams_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [oams_pkg::CFG_DATA_W-1:0] i_cfg_data;
    bit                              idle_on = 1'b1;
    int                              stall_reqs = 0;

    motor_run_predictor board = new();

    oams_in_if  in_ch ();
    oams_out_if out_ch ();

    obstacle_avoid_motor_sequencer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    task automatic write_reg(logic [oams_pkg::CFG_IDX_W-1:0] idx,
                             logic [oams_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    task automatic apply_settings(oams_pkg::t_cfg c);
        write_reg(oams_pkg::CFG_NEAR_LIMIT, {1'($urandom_range(1)), c.near_limit});
        write_reg(oams_pkg::CFG_FAR_LIMIT, {1'($urandom_range(1)), c.far_limit});
        write_reg(oams_pkg::CFG_PAUSE_MS, c.pause_ms);
        write_reg(oams_pkg::CFG_FRONT_BACKOFF_MS, c.front_backoff_ms);
        write_reg(oams_pkg::CFG_NEAR_BACKOFF_MS, c.near_backoff_ms);
        write_reg(oams_pkg::CFG_TURN_MS, c.turn_ms);
        write_reg(oams_pkg::CFG_NUDGE_MS, c.nudge_ms);
        // out-of-range index must leave every register alone
        write_reg(CFG_UNUSED_IDX, oams_pkg::CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_event(logic [oams_pkg::COUNT_W-1:0] cnt, logic fc, logic ll, logic rl,
                              logic cn);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.echo_count  <= cnt;
        in_ch.front_clear <= fc;
        in_ch.left_line   <= ll;
        in_ch.right_line  <= rl;
        in_ch.coin        <= cn;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        board.note_event(cnt, fc, ll, rl, cn);
    endtask

    task automatic wait_drained();
        while (board.due_actions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // echo counts cluster around the band limits, the rest spread over the full range
    function automatic logic [oams_pkg::COUNT_W-1:0] random_count(oams_pkg::t_cfg c);
        int target;
        int ticks;
        case ($urandom_range(2))
            0: return oams_pkg::COUNT_W'($urandom);
            1: target = int'(c.near_limit);
            default: target = int'(c.far_limit);
        endcase
        ticks = target * 100 / 34 + int'($urandom_range(8)) - 4;
        if (ticks < 0) ticks = 0;
        if (ticks > 65535) ticks = 65535;
        return oams_pkg::COUNT_W'(ticks);
    endfunction

    function automatic oams_pkg::t_cfg random_cfg(int unsigned lim_max);
        oams_pkg::t_cfg c;
        c.near_limit       = oams_pkg::LIMIT_W'($urandom_range(lim_max));
        c.far_limit        = oams_pkg::LIMIT_W'($urandom_range(lim_max));
        c.pause_ms         = oams_pkg::DUR_W'($urandom);
        c.front_backoff_ms = oams_pkg::DUR_W'($urandom);
        c.near_backoff_ms  = oams_pkg::DUR_W'($urandom);
        c.turn_ms          = oams_pkg::DUR_W'($urandom);
        c.nudge_ms         = oams_pkg::DUR_W'($urandom);
        return c;
    endfunction

    task automatic run_random_phase(oams_pkg::t_cfg c, int n, int stall_at);
        apply_settings(c);
        for (int k = 0; k < n; k++) begin
            if (k == stall_at) stall_reqs++;
            send_event(random_count(c), $urandom_range(99) < 70, 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        in_ch.valid <= 1'b0;
        wait_drained();
    endtask

    // output side: checks each transaction and decides ready for the next cycle
    initial begin
        int hold;
        int served;
        hold   = 0;
        served = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready)
                board.check_action(out_ch.action, out_ch.duration_ms, out_ch.distance,
                                   out_ch.last);
            if (served != stall_reqs) begin
                served = stall_reqs;
                hold   = STALL_CYCLES;
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        oams_pkg::t_cfg c;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.echo_count  <= '0;
        in_ch.front_clear <= 1'b1;
        in_ch.left_line   <= 1'b0;
        in_ch.right_line  <= 1'b0;
        in_ch.coin        <= 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: band edges, nudges, front obstacle, direction memory
        send_event(16'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(16'd65535, 1'b1, 1'b0, 1'b0, 1'b0);
        send_event(16'd65535, 1'b0, 1'b1, 1'b0, 1'b0);
        send_event(16'd882, 1'b1, 1'b0, 1'b1, 1'b1);
        send_event(16'd883, 1'b1, 1'b1, 1'b0, 1'b0);
        send_event(16'd1470, 1'b1, 1'b1, 1'b1, 1'b0);
        send_event(16'd1471, 1'b1, 1'b0, 1'b0, 1'b1);
        send_event(16'd1200, 1'b0, 1'b1, 1'b0, 1'b1);
        in_ch.valid <= 1'b0;
        wait_drained();

        // crossed limits with zero pause, turn and nudge
        c.near_limit       = 15'd1000;
        c.far_limit        = 15'd200;
        c.pause_ms         = '0;
        c.front_backoff_ms = '1;
        c.near_backoff_ms  = '1;
        c.turn_ms          = '0;
        c.nudge_ms         = '0;
        apply_settings(c);
        send_event(16'd1471, 1'b1, 1'b0, 1'b1, 1'b0);
        send_event(16'd3236, 1'b0, 1'b1, 1'b0, 1'b1);
        send_event(16'd294, 1'b1, 1'b1, 1'b1, 1'b0);
        in_ch.valid <= 1'b0;
        wait_drained();

        run_random_phase(random_cfg(2000), PHASE_ITEMS, -1);

        idle_on = 1'b0;
        c = '0;
        run_random_phase(c, PHASE_ITEMS, -1);
        idle_on = 1'b1;

        c.near_limit       = LIMIT_TOP;
        c.far_limit        = LIMIT_TOP;
        c.pause_ms         = '1;
        c.front_backoff_ms = '1;
        c.near_backoff_ms  = '1;
        c.turn_ms          = '1;
        c.nudge_ms         = '1;
        run_random_phase(c, PHASE_ITEMS, 8);

        c = random_cfg(3000);
        c.near_limit = oams_pkg::LIMIT_W'($urandom_range(3000, 1000));
        c.far_limit  = oams_pkg::LIMIT_W'($urandom_range(c.near_limit));
        run_random_phase(c, PHASE_ITEMS, -1);

        run_random_phase(random_cfg(LIMIT_TOP), PHASE_ITEMS, -1);

        c.near_limit       = oams_pkg::NEAR_LIMIT_RST;
        c.far_limit        = oams_pkg::FAR_LIMIT_RST;
        c.pause_ms         = oams_pkg::PAUSE_MS_RST;
        c.front_backoff_ms = oams_pkg::FRONT_BACKOFF_MS_RST;
        c.near_backoff_ms  = oams_pkg::NEAR_BACKOFF_MS_RST;
        c.turn_ms          = oams_pkg::TURN_MS_RST;
        c.nudge_ms         = oams_pkg::NUDGE_MS_RST;
        run_random_phase(c, PHASE_ITEMS, -1);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/oams_pkg.sv
hw/rtl/oams_in_if.sv
hw/rtl/oams_out_if.sv
hw/rtl/oams_cfg.sv
hw/rtl/oams_dist.sv
hw/rtl/oams_seq.sv
hw/rtl/obstacle_avoid_motor_sequencer.sv
hw/rtl/oams_checker.sv
tb/obstacle_avoid_motor_sequencer_tb.sv
